### design/bsa_pkg.sv
// Shared types and constants for the banker's-algorithm allocator.
package bsa_pkg;

   localparam int AVAIL_W     = 10;
   localparam int AVAIL_MAX   = 1023;
   localparam int FIELD_W     = 8;
   localparam int FIELD_COUNT = 4;
   localparam int ORDER_SLOTS = 8;
   localparam int SLOT_W      = 3;
   localparam int ORDER_W     = ORDER_SLOTS * SLOT_W;
   localparam int LEN_W       = 4;
   localparam int CFG_W       = 4;

   typedef enum logic [2:0] {
      FUNC_REQUEST   = 3'd0,
      FUNC_SET_ALLOC = 3'd1,
      FUNC_SET_MAX   = 3'd2,
      FUNC_RELEASE   = 3'd3,
      FUNC_ADD       = 3'd4,
      FUNC_REMOVE    = 3'd5,
      FUNC_SAFETY    = 3'd6,
      FUNC_UNDEFINED = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_OVER_NEED   = 3'd1,
      STATUS_OVER_AVAIL  = 3'd2,
      STATUS_UNSAFE      = 3'd3,
      STATUS_INVALID     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_INIT,
      S_SCAN,
      S_FINISH,
      S_RESP
   } state_type;

   typedef enum logic [3:0] {
      L_NOP,
      L_GRANT,
      L_UNDO,
      L_SET_ALLOC,
      L_SET_MAX,
      L_RELEASE,
      L_ADD,
      L_REMOVE,
      L_WORK_INIT,
      L_WORK_ADD
   } lane_op_type;

   typedef struct packed {
      logic need_over;
      logic avail_over;
      logic max_over;
      logic alloc_over;
      logic fits;
   } lane_flags_type;

endpackage

### design/bsa_lane.sv
// One resource-type lane: available count, maximum and allocation columns, work sum.
module bsa_lane import bsa_pkg::*; #(
   parameter int NUM_PROCESSES = 8,
   parameter int AMOUNT_BITS   = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_op_type              op,
   input  logic [$clog2(NUM_PROCESSES > 1 ? NUM_PROCESSES : 2)-1:0] row,
   input  logic [AMOUNT_BITS-1:0]   amt,
   output lane_flags_type           flags
);

   localparam int WORK_W = AVAIL_W + AMOUNT_BITS + 1;

   logic [AVAIL_W-1:0]     avail_ff, avail_in;
   logic [AMOUNT_BITS-1:0] max_ff   [NUM_PROCESSES];
   logic [AMOUNT_BITS-1:0] max_in   [NUM_PROCESSES];
   logic [AMOUNT_BITS-1:0] alloc_ff [NUM_PROCESSES];
   logic [AMOUNT_BITS-1:0] alloc_in [NUM_PROCESSES];
   logic [WORK_W-1:0]      work_ff, work_in;

   logic [AMOUNT_BITS-1:0] max_r, alloc_r, need_r, add_opnd;
   logic [WORK_W-1:0]      amt_w, avail_w, sum_w;
   logic [AVAIL_W-1:0]     sat_sum;

   always_comb begin
      max_r    = max_ff[row];
      alloc_r  = alloc_ff[row];
      need_r   = (max_r > alloc_r) ? AMOUNT_BITS'(max_r - alloc_r) : '0;
      amt_w    = WORK_W'(amt);
      avail_w  = WORK_W'(avail_ff);
      add_opnd = (op == L_RELEASE) ? alloc_r : amt;
      sum_w    = avail_w + WORK_W'(add_opnd);
      sat_sum  = (sum_w > WORK_W'(AVAIL_MAX)) ? AVAIL_W'(AVAIL_MAX) : sum_w[AVAIL_W-1:0];

      flags.need_over  = amt > need_r;
      flags.avail_over = amt_w > avail_w;
      flags.max_over   = amt > max_r;
      flags.alloc_over = alloc_r > amt;
      flags.fits       = WORK_W'(need_r) <= work_ff;
   end

   always_comb begin
      avail_in = avail_ff;
      max_in   = max_ff;
      alloc_in = alloc_ff;
      work_in  = work_ff;
      unique case (op)
         L_GRANT: begin
            avail_in      = AVAIL_W'(avail_w - amt_w);
            alloc_in[row] = AMOUNT_BITS'(alloc_r + amt);
         end
         L_UNDO: begin
            avail_in      = AVAIL_W'(avail_w + amt_w);
            alloc_in[row] = AMOUNT_BITS'(alloc_r - amt);
         end
         L_SET_ALLOC: alloc_in[row] = amt;
         L_SET_MAX:   max_in[row]   = amt;
         L_RELEASE: begin
            if (alloc_r != '0) begin
               avail_in      = sat_sum;
               alloc_in[row] = '0;
               max_in[row]   = '0;
            end
         end
         L_ADD:       avail_in = sat_sum;
         L_REMOVE:    avail_in = (avail_w > amt_w) ? AVAIL_W'(avail_w - amt_w) : '0;
         L_WORK_INIT: work_in  = avail_w;
         L_WORK_ADD:  work_in  = work_ff + WORK_W'(alloc_r);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         work_ff  <= '0;
         for (int i = 0; i < NUM_PROCESSES; i++) begin
            max_ff[i]   <= '0;
            alloc_ff[i] <= '0;
         end
      end else begin
         avail_ff <= avail_in;
         work_ff  <= work_in;
         max_ff   <= max_in;
         alloc_ff <= alloc_in;
      end
   end

endmodule

### design/banker_safety_allocator_top.sv
// Banker's-algorithm allocator: sequencer, resource lanes and flag merge.
// A table operation goes from idle through the execute state to the response state. A request
// or safety check scans one process row per cycle for up to rows+1 passes, going through the
// execute, scan init, scan and finish states before the response state.
// One transaction at a time.
// Synchronous reset clears all tables, available counts and the last check result.
module banker_safety_allocator_top import bsa_pkg::*; #(
   parameter int NUM_PROCESSES = 8,
   parameter int NUM_RESOURCES = 4,
   parameter int AMOUNT_BITS   = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [CFG_W-1:0]   csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [2:0]         req_process_index,
   input  logic [FIELD_W-1:0] req_amount_a,
   input  logic [FIELD_W-1:0] req_amount_b,
   input  logic [FIELD_W-1:0] req_amount_c,
   input  logic [FIELD_W-1:0] req_amount_d,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic               rsp_safe,
   output logic [ORDER_W-1:0] rsp_safe_order,
   output logic [LEN_W-1:0]   rsp_order_length
);

   localparam int ROW_W = $clog2(NUM_PROCESSES > 1 ? NUM_PROCESSES : 2);
   localparam int CNT_W = 5;

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        active_ff;
   func_type                func_ff, func_in;
   logic [3:0]              p_ff, p_in;
   logic [AMOUNT_BITS-1:0]  amt_ff [NUM_RESOURCES];
   logic [AMOUNT_BITS-1:0]  amt_in [NUM_RESOURCES];
   status_type              status_ff, status_in;
   logic [ROW_W-1:0]        scan_row_ff, scan_row_in;
   logic [NUM_PROCESSES-1:0] done_ff, done_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ORDER_W-1:0]      order_ff, order_in;
   logic                    progress_ff, progress_in;
   logic                    last_safe_ff, last_safe_in;
   logic [ORDER_W-1:0]      last_order_ff, last_order_in;
   logic [LEN_W-1:0]        last_len_ff, last_len_in;

   lane_op_type             lane_op;
   logic [ROW_W-1:0]        lane_row;
   lane_flags_type          flags [NUM_RESOURCES];
   logic                    any_need_over, any_avail_over, any_max_over, any_alloc_over;
   logic                    all_fit, row_ok, take, prog, last_row, scan_safe;
   logic [CNT_W-1:0]        rows;
   logic [FIELD_W-1:0]      req_amt [FIELD_COUNT];
   logic [15:0]             amt_ext;
   logic [3:0]              slot_idx;

   assign req_amt[0] = req_amount_a;
   assign req_amt[1] = req_amount_b;
   assign req_amt[2] = req_amount_c;
   assign req_amt[3] = req_amount_d;

   assign rows = (CNT_W'(active_ff) > CNT_W'(NUM_PROCESSES)) ? CNT_W'(NUM_PROCESSES)
                                                              : CNT_W'(active_ff);
   assign row_ok   = CNT_W'(p_ff) < rows;
   assign lane_row = (state_ff == S_SCAN) ? scan_row_ff : p_ff[ROW_W-1:0];

   genvar g;
   generate
      for (g = 0; g < NUM_RESOURCES; g++) begin : g_lane
         bsa_lane #(
            .NUM_PROCESSES (NUM_PROCESSES),
            .AMOUNT_BITS   (AMOUNT_BITS)
         ) u_lane (
            .clock (clock),
            .reset (reset),
            .op    (lane_op),
            .row   (lane_row),
            .amt   (amt_ff[g]),
            .flags (flags[g])
         );
      end
   endgenerate

   // merge lane findings
   always_comb begin
      any_need_over  = 1'b0;
      any_avail_over = 1'b0;
      any_max_over   = 1'b0;
      any_alloc_over = 1'b0;
      all_fit        = 1'b1;
      for (int j = 0; j < NUM_RESOURCES; j++) begin
         any_need_over  = any_need_over  | flags[j].need_over;
         any_avail_over = any_avail_over | flags[j].avail_over;
         any_max_over   = any_max_over   | flags[j].max_over;
         any_alloc_over = any_alloc_over | flags[j].alloc_over;
         all_fit        = all_fit        & flags[j].fits;
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      p_in          = p_ff;
      amt_in        = amt_ff;
      status_in     = status_ff;
      scan_row_in   = scan_row_ff;
      done_in       = done_ff;
      count_in      = count_ff;
      order_in      = order_ff;
      progress_in   = progress_ff;
      last_safe_in  = last_safe_ff;
      last_order_in = last_order_ff;
      last_len_in   = last_len_ff;
      lane_op       = L_NOP;
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      take          = 1'b0;
      prog          = 1'b0;
      last_row      = 1'b0;
      scan_safe     = 1'b0;
      amt_ext       = '0;
      slot_idx      = 4'(scan_row_ff);

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               func_in = func_type'(req_func);
               p_in    = {1'b0, req_process_index};
               for (int j = 0; j < NUM_RESOURCES; j++) begin
                  if (j < FIELD_COUNT) begin
                     amt_ext   = 16'(req_amt[2'(j)]);
                     amt_in[j] = amt_ext[AMOUNT_BITS-1:0];
                  end else begin
                     amt_in[j] = '0;
                  end
               end
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = STATUS_OK;
            state_in  = S_RESP;
            case (func_ff)
               FUNC_REQUEST: begin
                  if (!row_ok)             status_in = STATUS_INVALID;
                  else if (any_need_over)  status_in = STATUS_OVER_NEED;
                  else if (any_avail_over) status_in = STATUS_OVER_AVAIL;
                  else begin
                     lane_op  = L_GRANT;
                     state_in = S_SCAN_INIT;
                  end
               end
               FUNC_SET_ALLOC: begin
                  if (!row_ok || any_max_over) status_in = STATUS_INVALID;
                  else                         lane_op   = L_SET_ALLOC;
               end
               FUNC_SET_MAX: begin
                  if (!row_ok || any_alloc_over) status_in = STATUS_INVALID;
                  else                           lane_op   = L_SET_MAX;
               end
               FUNC_RELEASE: if (row_ok) lane_op = L_RELEASE;
               FUNC_ADD:     lane_op  = L_ADD;
               FUNC_REMOVE:  lane_op  = L_REMOVE;
               FUNC_SAFETY:  state_in = S_SCAN_INIT;
               default:      status_in = STATUS_INVALID;
            endcase
         end
         S_SCAN_INIT: begin
            lane_op     = L_WORK_INIT;
            scan_row_in = '0;
            done_in     = '0;
            count_in    = '0;
            order_in    = '0;
            progress_in = 1'b0;
            state_in    = (rows == '0) ? S_FINISH : S_SCAN;
         end
         S_SCAN: begin
            take     = !done_ff[scan_row_ff] && all_fit;
            prog     = progress_ff | take;
            last_row = (CNT_W'(scan_row_ff) + CNT_W'(1)) == rows;
            if (take) begin
               lane_op              = L_WORK_ADD;
               done_in[scan_row_ff] = 1'b1;
               count_in             = count_ff + CNT_W'(1);
               for (int k = 0; k < ORDER_SLOTS; k++) begin
                  if (count_ff == CNT_W'(k)) order_in[SLOT_W*k +: SLOT_W] = slot_idx[2:0];
               end
            end
            if (last_row) begin
               scan_row_in = '0;
               progress_in = 1'b0;
               // start another pass only while some row finished
               if (!prog) state_in = S_FINISH;
            end else begin
               scan_row_in = ROW_W'(scan_row_ff + ROW_W'(1));
               progress_in = prog;
            end
         end
         S_FINISH: begin
            scan_safe     = count_ff == rows;
            last_safe_in  = scan_safe;
            last_order_in = order_ff;
            last_len_in   = count_ff[LEN_W-1:0];
            if (func_ff == FUNC_REQUEST && !scan_safe) begin
               lane_op   = L_UNDO;
               status_in = STATUS_UNSAFE;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         status_ff     <= STATUS_OK;
         scan_row_ff   <= '0;
         done_ff       <= '0;
         count_ff      <= '0;
         order_ff      <= '0;
         progress_ff   <= 1'b0;
         last_safe_ff  <= 1'b0;
         last_order_ff <= '0;
         last_len_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         if (csr_write_enable) active_ff <= csr_write_data;
         status_ff     <= status_in;
         scan_row_ff   <= scan_row_in;
         done_ff       <= done_in;
         count_ff      <= count_in;
         order_ff      <= order_in;
         progress_ff   <= progress_in;
         last_safe_ff  <= last_safe_in;
         last_order_ff <= last_order_in;
         last_len_ff   <= last_len_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      p_ff    <= p_in;
      amt_ff  <= amt_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_safe         = last_safe_ff;
   assign rsp_safe_order   = last_order_ff;
   assign rsp_order_length = last_len_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_FINISH) |-> count_ff <= rows)
      else $error("finished-row count exceeds active rows");

   a_done_matches_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> $countones(done_ff) == count_ff)
      else $error("done bits disagree with finished-row count");

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("new transaction taken while a response is pending");

   a_unsafe_only_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_UNSAFE) |-> (!rsp_safe && func_ff == FUNC_REQUEST))
      else $error("rollback reported without a failed request check");

endmodule

### tb/banker_safety_allocator_top_tb.sv
// Self-checking testbench for the banker's-algorithm allocator top level.
`timescale 1ns / 100ps

class bank_scoreboard;
   // Predicted allocator state
   int unsigned avail[4];
   int unsigned max_t[8][4];
   int unsigned alloc_t[8][4];
   int unsigned need_t[8][4];
   int unsigned active_rows;
   bit          last_safe;
   logic [23:0] last_order;
   logic [3:0]  last_length;
   logic [31:0] expected_q[$];
   int          error_count;

   function new();
      foreach (avail[j]) avail[j] = 0;
      foreach (max_t[i, j]) begin
         max_t[i][j] = 0;
         alloc_t[i][j] = 0;
         need_t[i][j] = 0;
      end
      active_rows = 0;
      last_safe = 0;
      last_order = '0;
      last_length = '0;
      error_count = 0;
   endfunction

   function void set_rows(logic [3:0] value);
      active_rows = value;
   endfunction

   function int unsigned rows();
      return active_rows > 8 ? 8 : active_rows;
   endfunction

   function void fix_need(int p);
      for (int j = 0; j < 4; j++)
         need_t[p][j] = max_t[p][j] > alloc_t[p][j] ? max_t[p][j] - alloc_t[p][j] : 0;
   endfunction

   function void scan_safety();
      int unsigned work[4];
      bit          done[8];
      int unsigned count;
      logic [23:0] order;
      bit          progress;
      bit          fits;
      count = 0;
      order = '0;
      foreach (work[j]) work[j] = avail[j];
      foreach (done[i]) done[i] = 0;
      do begin
         progress = 0;
         for (int i = 0; i < rows(); i++) begin
            if (done[i]) continue;
            fits = 1;
            for (int j = 0; j < 4; j++)
               if (need_t[i][j] > work[j]) fits = 0;
            if (!fits) continue;
            for (int j = 0; j < 4; j++) work[j] += alloc_t[i][j];
            done[i] = 1;
            if (count < 8) order |= 24'(i) << (3 * count);
            count++;
            progress = 1;
         end
      end while (progress);
      last_safe = (count == rows());
      last_order = order;
      last_length = 4'(count);
   endfunction

   function void note_request(bsa_pkg::func_type f, logic [2:0] p, logic [7:0] a[4]);
      bsa_pkg::status_type st;
      bit row_ok;
      logic [31:0] exp_r;
      st = bsa_pkg::STATUS_OK;
      row_ok = p < rows();
      case (f)
         bsa_pkg::FUNC_REQUEST: begin
            if (!row_ok) st = bsa_pkg::STATUS_INVALID;
            else begin
               for (int j = 0; j < 4; j++)
                  if (a[j] > need_t[p][j]) st = bsa_pkg::STATUS_OVER_NEED;
               if (st == bsa_pkg::STATUS_OK)
                  for (int j = 0; j < 4; j++)
                     if (a[j] > avail[j]) st = bsa_pkg::STATUS_OVER_AVAIL;
               if (st == bsa_pkg::STATUS_OK) begin
                  for (int j = 0; j < 4; j++) begin
                     avail[j] -= a[j];
                     alloc_t[p][j] += a[j];
                     need_t[p][j] -= a[j];
                  end
                  scan_safety();
                  if (!last_safe) begin
                     for (int j = 0; j < 4; j++) begin
                        avail[j] += a[j];
                        alloc_t[p][j] -= a[j];
                        need_t[p][j] += a[j];
                     end
                     st = bsa_pkg::STATUS_UNSAFE;
                  end
               end
            end
         end
         bsa_pkg::FUNC_SET_ALLOC: begin
            if (!row_ok) st = bsa_pkg::STATUS_INVALID;
            else begin
               for (int j = 0; j < 4; j++)
                  if (a[j] > max_t[p][j]) st = bsa_pkg::STATUS_INVALID;
               if (st == bsa_pkg::STATUS_OK) begin
                  for (int j = 0; j < 4; j++) alloc_t[p][j] = a[j];
                  fix_need(p);
               end
            end
         end
         bsa_pkg::FUNC_SET_MAX: begin
            if (!row_ok) st = bsa_pkg::STATUS_INVALID;
            else begin
               for (int j = 0; j < 4; j++)
                  if (a[j] < alloc_t[p][j]) st = bsa_pkg::STATUS_INVALID;
               if (st == bsa_pkg::STATUS_OK) begin
                  for (int j = 0; j < 4; j++) max_t[p][j] = a[j];
                  fix_need(p);
               end
            end
         end
         bsa_pkg::FUNC_RELEASE: begin
            if (row_ok)
               for (int j = 0; j < 4; j++)
                  if (alloc_t[p][j] > 0) begin
                     avail[j] = avail[j] + alloc_t[p][j] > 1023 ? 1023
                                : avail[j] + alloc_t[p][j];
                     alloc_t[p][j] = 0;
                     max_t[p][j] = 0;
                     need_t[p][j] = 0;
                  end
         end
         bsa_pkg::FUNC_ADD:
            for (int j = 0; j < 4; j++)
               avail[j] = avail[j] + a[j] > 1023 ? 1023 : avail[j] + a[j];
         bsa_pkg::FUNC_REMOVE:
            for (int j = 0; j < 4; j++)
               avail[j] = avail[j] > a[j] ? avail[j] - a[j] : 0;
         bsa_pkg::FUNC_SAFETY: scan_safety();
         default: st = bsa_pkg::STATUS_INVALID;
      endcase
      exp_r = {st, last_safe, last_order, last_length};
      expected_q.insert(expected_q.size(), exp_r);
   endfunction

   function void check_result(logic [2:0] st, logic sf, logic [23:0] ord, logic [3:0] len);
      logic [31:0] exp_r;
      if (expected_q.size() == 0) begin
         $error("unexpected result transaction");
         error_count++;
         return;
      end
      exp_r = expected_q.pop_front();
      if (st !== exp_r[31:29]) begin
         $error("status expected %0d actual %0d", exp_r[31:29], st);
         error_count++;
      end
      if (sf !== exp_r[28]) begin
         $error("safe expected %0d actual %0d", exp_r[28], sf);
         error_count++;
      end
      if (ord !== exp_r[27:4]) begin
         $error("safe_order expected %h actual %h", exp_r[27:4], ord);
         error_count++;
      end
      if (len !== exp_r[3:0]) begin
         $error("order_length expected %0d actual %0d", exp_r[3:0], len);
         error_count++;
      end
   endfunction
endclass

module banker_safety_allocator_top_tb;
   import bsa_pkg::*;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [CFG_W-1:0]   csr_write_data;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_func;
   logic [2:0]         req_process_index;
   logic [FIELD_W-1:0] req_amount_a;
   logic [FIELD_W-1:0] req_amount_b;
   logic [FIELD_W-1:0] req_amount_c;
   logic [FIELD_W-1:0] req_amount_d;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_status;
   logic               rsp_safe;
   logic [ORDER_W-1:0] rsp_safe_order;
   logic [LEN_W-1:0]   rsp_order_length;

   bank_scoreboard ledger;

   banker_safety_allocator_top DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_process_index(req_process_index), .req_amount_a(req_amount_a),
      .req_amount_b(req_amount_b), .req_amount_c(req_amount_c),
      .req_amount_d(req_amount_d), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_safe(rsp_safe), .rsp_safe_order(rsp_safe_order),
      .rsp_order_length(rsp_order_length)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("banker_safety_allocator_top_tb: errors");
      $finish;
   end

   // Receiver: random stall per transaction, checked at the accepting edge
   initial begin
      int unsigned gap;
      rsp_stall = 1'b1;
      wait (reset === 1'b0);
      forever begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         ledger.check_result(rsp_status, rsp_safe, rsp_safe_order, rsp_order_length);
      end
   end

   task automatic send_op(func_type f, logic [2:0] p, logic [7:0] a, logic [7:0] b,
                          logic [7:0] c, logic [7:0] d, bit no_gap = 0);
      int unsigned gap;
      logic [7:0] amt[4];
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_process_index <= p;
      req_amount_a <= a;
      req_amount_b <= b;
      req_amount_c <= c;
      req_amount_d <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      amt[0] = a; amt[1] = b; amt[2] = c; amt[3] = d;
      ledger.note_request(f, p, amt);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.expected_q.size() != 0) @(posedge clock);
      repeat (90) @(posedge clock);
   endtask

   task automatic write_rows(logic [3:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ledger.set_rows(value);
   endtask

   // Small amounts keep requests inside need and available most of the time
   function automatic logic [7:0] pick_amount();
      case ($urandom_range(0, 9))
         0: return 8'hFF;
         1: return 8'h00;
         2: return 8'($urandom);
         default: return 8'($urandom_range(0, 12));
      endcase
   endfunction

   task automatic random_op();
      func_type f;
      logic [2:0] p;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      p = 3'($urandom_range(0, 7));
      if (pick < 35) f = FUNC_REQUEST;
      else if (pick < 47) f = FUNC_SET_MAX;
      else if (pick < 55) f = FUNC_SET_ALLOC;
      else if (pick < 65) f = FUNC_RELEASE;
      else if (pick < 78) f = FUNC_ADD;
      else if (pick < 85) f = FUNC_REMOVE;
      else if (pick < 97) f = FUNC_SAFETY;
      else f = FUNC_UNDEFINED;
      // Requests mostly ask for part of the row's current need
      if (f == FUNC_REQUEST && $urandom_range(0, 3) != 0 && p < ledger.rows())
         send_op(f, p, 8'($urandom_range(0, ledger.need_t[p][0])),
                 8'($urandom_range(0, ledger.need_t[p][1])),
                 8'($urandom_range(0, ledger.need_t[p][2])),
                 8'($urandom_range(0, ledger.need_t[p][3])));
      else if (f == FUNC_SET_ALLOC && $urandom_range(0, 3) != 0 && p < ledger.rows())
         send_op(f, p, 8'($urandom_range(0, ledger.max_t[p][0])),
                 8'($urandom_range(0, ledger.max_t[p][1])),
                 8'($urandom_range(0, ledger.max_t[p][2])),
                 8'($urandom_range(0, ledger.max_t[p][3])));
      else
         send_op(f, p, pick_amount(), pick_amount(), pick_amount(), pick_amount());
   endtask

   // Back-to-back safety checks keep valid high over successive transactions
   task automatic random_op_burst();
      send_op(FUNC_SAFETY, 3'($urandom), pick_amount(), pick_amount(), pick_amount(),
              pick_amount(), 1);
   endtask

   initial begin
      logic [3:0] row_settings[6];
      ledger = new();
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_func <= FUNC_SAFETY;
      req_process_index <= '0;
      req_amount_a <= '0;
      req_amount_b <= '0;
      req_amount_c <= '0;
      req_amount_d <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero rows first, then full table
      send_op(FUNC_REQUEST, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_op(FUNC_RELEASE, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_op(FUNC_SAFETY, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      drain();
      write_rows(4'd8);
      send_op(FUNC_ADD, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_ADD, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_ADD, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_ADD, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_ADD, 3'd0, 8'hFF, 8'h01, 8'h80, 8'h7F);
      send_op(FUNC_REMOVE, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_SET_MAX, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_SET_ALLOC, 3'd7, 8'hF0, 8'h0F, 8'hAA, 8'h55);
      send_op(FUNC_SET_MAX, 3'd7, 8'h01, 8'h01, 8'h01, 8'h01);
      send_op(FUNC_SET_MAX, 3'd3, 8'h10, 8'h10, 8'h10, 8'h10);
      send_op(FUNC_SET_ALLOC, 3'd3, 8'h20, 8'h00, 8'h00, 8'h00);
      send_op(FUNC_REQUEST, 3'd3, 8'h11, 8'h00, 8'h00, 8'h00);
      send_op(FUNC_REQUEST, 3'd3, 8'h10, 8'h10, 8'h10, 8'h10);
      send_op(FUNC_SET_MAX, 3'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_REQUEST, 3'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_RELEASE, 3'd7, 8'd0, 8'd0, 8'd0, 8'd0);
      send_op(FUNC_RELEASE, 3'd3, 8'd0, 8'd0, 8'd0, 8'd0);
      send_op(FUNC_REMOVE, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_REMOVE, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_op(FUNC_REQUEST, 3'd2, 8'h01, 8'h00, 8'h00, 8'h00);
      send_op(FUNC_UNDEFINED, 3'd5, 8'h12, 8'h34, 8'h56, 8'h78);
      send_op(FUNC_SAFETY, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      drain();

      // Random phases across row counts, including values above the table size
      row_settings[0] = 4'd8; row_settings[1] = 4'd1; row_settings[2] = 4'd15;
      row_settings[3] = 4'd4; row_settings[4] = 4'd0; row_settings[5] = 4'd6;
      foreach (row_settings[k]) begin
         write_rows(row_settings[k]);
         send_op(FUNC_ADD, 3'd0, 8'h40, 8'h40, 8'h40, 8'h40);
         for (int n = 0; n < 80; n++) begin
            random_op();
            if (n == 50) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (ledger.expected_q.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 19) == 0)
               for (int m = 0; m < 6; m++) random_op_burst();
         end
         drain();
      end

      if (ledger.error_count == 0) begin
         $display("banker_safety_allocator_top_tb: clean");
      end else begin
         $display("banker_safety_allocator_top_tb: errors");
      end
      $finish;
   end
endmodule
